@@ src/tegl_pkg.sv @@
// shared types and constants of the text escape glyph layout block
package tegl_pkg;

    localparam int TABLE_ENTRIES = 256;
    localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
    localparam int PEN_BITS      = 24;
    localparam int CODE_W        = 21;
    localparam int METRIC_W      = 16;
    localparam int OUT_PEN_W     = 24;
    localparam int PAL_W         = 3;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    localparam logic [1:0] ACT_BEGIN = 2'd0;
    localparam logic [1:0] ACT_CHAR  = 2'd1;
    localparam logic [1:0] ACT_LOAD  = 2'd2;

    localparam logic [CODE_W-1:0] CH_DOLLAR  = 21'h24;
    localparam logic [CODE_W-1:0] CH_C       = 21'h63;
    localparam logic [CODE_W-1:0] CH_ZERO    = 21'h30;
    localparam logic [CODE_W-1:0] CH_SEVEN   = 21'h37;
    localparam logic [CODE_W-1:0] CH_NEWLINE = 21'h0A;
    localparam logic [CODE_W-1:0] CH_SPACE   = 21'h20;

    typedef enum logic [1:0] {
        ESC_NONE,
        ESC_DOLLAR,
        ESC_COLOR
    } esc_phase_t;

    typedef enum logic [2:0] {
        OP_BEGIN,
        OP_LOAD,
        OP_DRAW,
        OP_NEWLINE,
        OP_SPACE
    } op_kind_t;

    typedef struct packed {
        op_kind_t              kind;
        logic [CODE_W-1:0]     code;
        logic [TABLE_AW-1:0]   addr;
        logic [PAL_W-1:0]      palette;
        logic [METRIC_W-1:0]   metric;
        logic                  miss;
        logic                  last;
    } op_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

endpackage

@@ src/tegl_front.sv @@
// front end: escape decoding and classification of input words into ops
module tegl_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    action,
    input  logic [tegl_pkg::CODE_W-1:0]   char_code,
    input  logic [tegl_pkg::METRIC_W-1:0] metric_value,
    input  tegl_pkg::queue_stat_t         q_stat,
    output logic                          push_valid,
    output tegl_pkg::op_t                 push_op
);

    tegl_pkg::esc_phase_t          phase_reg, phase_next;
    logic [tegl_pkg::PAL_W-1:0]    palette_reg, palette_next;
    logic                          pend_valid_reg, pend_valid_next;
    tegl_pkg::op_t                 pend_op_reg, pend_op_next;
    logic                          accept;
    logic                          first_valid;
    tegl_pkg::op_t                 first_op;

    // plain character with no escape handling
    function automatic tegl_pkg::op_t make_char_op(
        input logic [tegl_pkg::CODE_W-1:0] code,
        input logic [tegl_pkg::PAL_W-1:0]  pal,
        input logic                        last
    );
        tegl_pkg::op_t op;
        op.code    = code;
        op.palette = pal;
        op.metric  = '0;
        op.last    = last;
        op.miss    = 1'b0;
        op.addr    = tegl_pkg::TABLE_AW'(code);
        if (code == tegl_pkg::CH_NEWLINE)
        begin
            op.kind = tegl_pkg::OP_NEWLINE;
        end
        else if (code == tegl_pkg::CH_SPACE)
        begin
            op.kind = tegl_pkg::OP_SPACE;
            op.addr = tegl_pkg::TABLE_AW'(tegl_pkg::CH_SPACE);
        end
        else
        begin
            op.kind = tegl_pkg::OP_DRAW;
            op.miss = (code >= tegl_pkg::CODE_W'(tegl_pkg::TABLE_ENTRIES));
        end
        return op;
    endfunction

    assign in_stall   = pend_valid_reg || q_stat.full;
    assign accept     = in_valid && !in_stall;
    assign push_valid = pend_valid_reg || (accept && first_valid);
    assign push_op    = pend_valid_reg ? pend_op_reg : first_op;

    always_comb
    begin
        phase_next      = phase_reg;
        palette_next    = palette_reg;
        pend_valid_next = pend_valid_reg && q_stat.full;
        pend_op_next    = pend_op_reg;
        first_valid     = 1'b0;
        first_op        = make_char_op(char_code, palette_reg, 1'b1);
        if (accept)
        begin
            unique case (action)
                tegl_pkg::ACT_BEGIN:
                begin
                    phase_next      = tegl_pkg::ESC_NONE;
                    palette_next    = '0;
                    first_valid     = 1'b1;
                    first_op.kind   = tegl_pkg::OP_BEGIN;
                    first_op.metric = metric_value;
                end
                tegl_pkg::ACT_LOAD:
                begin
                    // loads beyond the table are dropped here
                    first_valid     = (char_code < tegl_pkg::CODE_W'(tegl_pkg::TABLE_ENTRIES));
                    first_op.kind   = tegl_pkg::OP_LOAD;
                    first_op.metric = metric_value;
                    first_op.addr   = tegl_pkg::TABLE_AW'(char_code);
                end
                tegl_pkg::ACT_CHAR:
                begin
                    unique case (phase_reg)
                        tegl_pkg::ESC_COLOR:
                        begin
                            phase_next = tegl_pkg::ESC_NONE;
                            if (char_code >= tegl_pkg::CH_ZERO && char_code <= tegl_pkg::CH_SEVEN)
                            begin
                                palette_next = tegl_pkg::PAL_W'(char_code - tegl_pkg::CH_ZERO);
                            end
                            else
                            begin
                                // broken color escape: plain char in palette 0, even a dollar
                                palette_next = '0;
                                first_valid  = 1'b1;
                                first_op     = make_char_op(char_code, '0, 1'b1);
                            end
                        end
                        tegl_pkg::ESC_DOLLAR:
                        begin
                            if (char_code == tegl_pkg::CH_C)
                            begin
                                phase_next = tegl_pkg::ESC_COLOR;
                            end
                            else
                            begin
                                // broken dollar escape: emit dollar, then char or new escape
                                first_valid = 1'b1;
                                first_op    = make_char_op(tegl_pkg::CH_DOLLAR, palette_reg,
                                    char_code == tegl_pkg::CH_DOLLAR ||
                                    char_code == tegl_pkg::CH_NEWLINE ||
                                    char_code == tegl_pkg::CH_SPACE);
                                if (char_code == tegl_pkg::CH_DOLLAR)
                                begin
                                    phase_next = tegl_pkg::ESC_DOLLAR;
                                end
                                else
                                begin
                                    phase_next      = tegl_pkg::ESC_NONE;
                                    pend_valid_next = 1'b1;
                                    pend_op_next    = make_char_op(char_code, palette_reg, 1'b1);
                                end
                            end
                        end
                        default:
                        begin
                            if (char_code == tegl_pkg::CH_DOLLAR)
                            begin
                                phase_next = tegl_pkg::ESC_DOLLAR;
                            end
                            else
                            begin
                                first_valid = 1'b1;
                            end
                        end
                    endcase
                end
                default:
                begin
                    first_valid = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= tegl_pkg::ESC_NONE;
            palette_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg      <= phase_next;
            palette_reg    <= palette_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_op_reg <= pend_op_next;
    end

endmodule

@@ src/tegl_queue.sv @@
// short op queue between the front end and the back end
module tegl_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push_valid,
    input  tegl_pkg::op_t         push_op,
    input  logic                  pop,
    output tegl_pkg::op_t         head,
    output tegl_pkg::queue_stat_t stat
);

    tegl_pkg::op_t                  slot_reg [tegl_pkg::QUEUE_DEPTH];
    logic [tegl_pkg::QUEUE_AW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [tegl_pkg::QUEUE_AW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [tegl_pkg::QUEUE_AW:0]    count_reg, count_next;
    logic                           do_push;
    logic                           do_pop;

    assign stat.full  = (count_reg == (tegl_pkg::QUEUE_AW + 1)'(tegl_pkg::QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push_valid && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

@@ src/tegl_back.sv @@
// back end: advance table, pen accumulators and the output register
module tegl_back (
    input  logic                           clk,
    input  logic                           rst_n,
    input  tegl_pkg::op_t                  head,
    input  tegl_pkg::queue_stat_t          q_stat,
    output logic                           pop,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tegl_pkg::CODE_W-1:0]    glyph_code,
    output logic [tegl_pkg::PAL_W-1:0]     palette_index,
    output logic [tegl_pkg::OUT_PEN_W-1:0] pen_x,
    output logic [tegl_pkg::OUT_PEN_W-1:0] pen_y,
    output logic                           table_miss,
    output logic                           last_of_run
);

    logic [tegl_pkg::METRIC_W-1:0] table_mem [tegl_pkg::TABLE_ENTRIES];
    logic [tegl_pkg::METRIC_W-1:0] rdata_reg;
    logic                          s2_valid_reg, s2_valid_next;
    tegl_pkg::op_t                 s2_op_reg;
    logic [tegl_pkg::PEN_BITS-1:0] pen_x_reg, pen_x_next;
    logic [tegl_pkg::PEN_BITS-1:0] pen_y_reg, pen_y_next;
    logic [tegl_pkg::METRIC_W-1:0] line_step_reg, line_step_next;
    logic                          out_valid_reg, out_valid_next;
    logic                          advance;
    logic                          emit;

    function automatic logic [tegl_pkg::PEN_BITS-1:0] pen_sat_add(
        input logic [tegl_pkg::PEN_BITS-1:0] a,
        input logic [tegl_pkg::METRIC_W-1:0] b
    );
        logic [tegl_pkg::PEN_BITS:0] s;
        s = {1'b0, a} + (tegl_pkg::PEN_BITS + 1)'(b);
        return s[tegl_pkg::PEN_BITS] ? '1 : s[tegl_pkg::PEN_BITS-1:0];
    endfunction

    // whole back end holds while a finished word waits at the output
    assign advance   = !out_valid_reg || !out_stall;
    assign pop       = advance && !q_stat.empty;
    assign emit      = advance && s2_valid_reg && (s2_op_reg.kind == tegl_pkg::OP_DRAW);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        pen_x_next     = pen_x_reg;
        pen_y_next     = pen_y_reg;
        line_step_next = line_step_reg;
        out_valid_next = out_valid_reg;
        s2_valid_next  = s2_valid_reg;
        if (advance)
        begin
            s2_valid_next  = !q_stat.empty;
            out_valid_next = emit;
            if (s2_valid_reg)
            begin
                unique case (s2_op_reg.kind)
                    tegl_pkg::OP_BEGIN:
                    begin
                        pen_x_next     = '0;
                        pen_y_next     = '0;
                        line_step_next = s2_op_reg.metric;
                    end
                    tegl_pkg::OP_DRAW:
                    begin
                        if (!s2_op_reg.miss)
                        begin
                            pen_x_next = pen_sat_add(pen_x_reg, rdata_reg);
                        end
                    end
                    tegl_pkg::OP_NEWLINE:
                    begin
                        pen_x_next = '0;
                        pen_y_next = pen_sat_add(pen_y_reg, line_step_reg);
                    end
                    tegl_pkg::OP_SPACE:
                    begin
                        pen_x_next = pen_sat_add(pen_x_reg, rdata_reg);
                    end
                    default:
                    begin
                        pen_x_next = pen_x_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            pen_x_reg     <= '0;
            pen_y_reg     <= '0;
            line_step_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            pen_x_reg     <= pen_x_next;
            pen_y_reg     <= pen_y_next;
            line_step_reg <= line_step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // table read is registered; a load written here is seen by the next op
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (head.kind == tegl_pkg::OP_LOAD)
            begin
                table_mem[head.addr] <= head.metric;
            end
            rdata_reg <= table_mem[head.addr];
            s2_op_reg <= head;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            glyph_code    <= s2_op_reg.code;
            palette_index <= s2_op_reg.palette;
            pen_x         <= tegl_pkg::OUT_PEN_W'(pen_x_reg);
            pen_y         <= tegl_pkg::OUT_PEN_W'(pen_y_reg);
            table_miss    <= s2_op_reg.miss;
            last_of_run   <= s2_op_reg.last;
        end
    end

endmodule

@@ src/text_escape_glyph_layout_core.sv @@
// top level of the text escape glyph layout block
//
//  channel | handshake            | fields
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | action, char_code, metric_value
//  out     | out_valid / out_stall| glyph_code, palette_index, pen_x, pen_y,
//          |                      | table_miss, last_of_run
//
// one input word per cycle while the op queue is not full; a broken dollar escape
// that expands to two ops holds the input until its second op has been pushed
// an accepted word passes through a queue slot, then the registered read of the
// 256-entry advance table and the output register in the back end
// the four-entry op queue takes the front's words until full while the output stalls
// reset clears pen, line height, escape state and palette; the table is not cleared
module text_escape_glyph_layout_core (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     action,
    input  logic [tegl_pkg::CODE_W-1:0]    char_code,
    input  logic [tegl_pkg::METRIC_W-1:0]  metric_value,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [tegl_pkg::CODE_W-1:0]    glyph_code,
    output logic [tegl_pkg::PAL_W-1:0]     palette_index,
    output logic [tegl_pkg::OUT_PEN_W-1:0] pen_x,
    output logic [tegl_pkg::OUT_PEN_W-1:0] pen_y,
    output logic                           table_miss,
    output logic                           last_of_run
);

    tegl_pkg::queue_stat_t q_stat;
    tegl_pkg::op_t         push_op;
    tegl_pkg::op_t         head;
    logic                  push_valid;
    logic                  pop;

    tegl_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .action       (action),
        .char_code    (char_code),
        .metric_value (metric_value),
        .q_stat       (q_stat),
        .push_valid   (push_valid),
        .push_op      (push_op)
    );

    tegl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_op    (push_op),
        .pop        (pop),
        .head       (head),
        .stat       (q_stat)
    );

    tegl_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_stat        (q_stat),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .glyph_code    (glyph_code),
        .palette_index (palette_index),
        .pen_x         (pen_x),
        .pen_y         (pen_y),
        .table_miss    (table_miss),
        .last_of_run   (last_of_run)
    );

endmodule

@@ src/tegl_checker.sv @@
// port-level checks of the glyph layout block and their binding
module tegl_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [tegl_pkg::CODE_W-1:0]    glyph_code,
    input logic [tegl_pkg::OUT_PEN_W-1:0] pen_x,
    input logic                           table_miss,
    input logic                           last_of_run
);

    // a stalled output word stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(glyph_code) && $stable(pen_x))
        else $error("output word changed while stalled");

    // miss flag follows the code range
    a_miss: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
        table_miss == (glyph_code >= tegl_pkg::CODE_W'(tegl_pkg::TABLE_ENTRIES)))
        else $error("table_miss disagrees with glyph_code");

    // only the dollar of a broken escape can be followed by a second glyph
    a_first_is_dollar: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> glyph_code == tegl_pkg::CH_DOLLAR)
        else $error("non-final glyph is not a dollar");

    // no output word once reset has been seen at an edge
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid during reset");

endmodule

bind text_escape_glyph_layout_core tegl_checker u_tegl_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .glyph_code  (glyph_code),
    .pen_x       (pen_x),
    .table_miss  (table_miss),
    .last_of_run (last_of_run)
);
